@@ src/dda_pkg.sv @@
package dda_pkg;

    localparam int DimW    = 13;
    localparam int CoordW  = 18;
    localparam int RangeW  = 18;
    localparam int PosW    = 48;
    localparam int FracW   = 32;
    localparam int StepW   = 13;
    localparam int ColorW  = 8;
    localparam int PixW    = 12;
    localparam int AddrW   = 26;

    localparam int DivNumW = 51;
    localparam int DivDenW = 30;
    localparam int DivQW   = 33;
    localparam int DivCntW = 6;

    localparam logic [StepW-1:0] STEP_MAX = {StepW{1'b1}};

    typedef enum logic [1:0] {
        STS_PIXEL = 2'd0,
        STS_SKIP  = 2'd1,
        STS_DONE  = 2'd2
    } t_status;

    typedef struct packed {
        logic cap;
        logic prep;
        logic mul;
        logic zero_line;
        logic start_major;
        logic take_major;
        logic start_minor;
        logic commit;
        logic step_add;
        logic step_pix;
        logic step_clamp;
        logic step_lin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic total_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ src/dda_div.sv @@
module dda_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dda_pkg::DivNumW-1:0]  i_num,
    input  logic [dda_pkg::DivDenW-1:0]  i_den,
    output logic                         o_done,
    output logic [dda_pkg::DivQW-1:0]    o_quo
);
    import dda_pkg::*;

    logic [DivCntW-1:0] r_cnt;
    logic               r_done;
    logic [DivDenW-1:0] r_rem;
    logic [DivDenW-1:0] r_den;
    logic [DivQW-1:0]   r_q;

    logic [DivDenW:0]   w_shift;
    logic [DivDenW:0]   w_diff;
    logic               w_ge;

    assign w_shift = {r_rem, r_q[DivQW-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DivCntW'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= DivCntW'(DivQW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DivCntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DivDenW'(i_num[DivNumW-1:DivQW]);
            r_q   <= i_num[DivQW-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DivDenW-1:0] : w_shift[DivDenW-1:0];
            r_q   <= {r_q[DivQW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

@@ src/dda_dp.sv @@
module dda_dp #(
    parameter int BYTES_PER_PIXEL = 4,
    parameter int MAX_DIM         = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dda_pkg::t_cmd                     i_cmd,
    output dda_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [dda_pkg::DimW-1:0]          i_cfg_data,
    input  logic signed [dda_pkg::CoordW-1:0] i_first_x,
    input  logic signed [dda_pkg::CoordW-1:0] i_first_y,
    input  logic signed [dda_pkg::CoordW-1:0] i_second_x,
    input  logic signed [dda_pkg::CoordW-1:0] i_second_y,
    input  logic [dda_pkg::ColorW-1:0]        i_red_in,
    input  logic [dda_pkg::ColorW-1:0]        i_green_in,
    input  logic [dda_pkg::ColorW-1:0]        i_blue_in,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [1:0]                        o_status,
    output logic [dda_pkg::PixW-1:0]          o_pixel_x,
    output logic [dda_pkg::PixW-1:0]          o_pixel_y,
    output logic [dda_pkg::AddrW-1:0]         o_byte_address,
    output logic [dda_pkg::ColorW-1:0]        o_red_out,
    output logic [dda_pkg::ColorW-1:0]        o_green_out,
    output logic [dda_pkg::ColorW-1:0]        o_blue_out,
    output logic                              o_last_pixel
);
    import dda_pkg::*;

    localparam int ProdW = DivQW + DimW;
    localparam int LinW  = 2 * PixW + 1;
    localparam int FullW = LinW + 3;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    function automatic logic [DimW-1:0] dim_of(input logic [DimW-1:0] r);
        logic [DimW-1:0] v;
        v = r;
        if (r == '0) begin
            v = DimW'(1);
        end else if (r > DimW'(MAX_DIM)) begin
            v = DimW'(MAX_DIM);
        end
        return v;
    endfunction

    logic [DimW-1:0]          r_frame_w;
    logic [DimW-1:0]          r_frame_h;

    logic signed [CoordW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [3*ColorW-1:0]      r_color_in;

    logic                     r_axis_y;
    logic                     r_neg;
    logic [RangeW-1:0]        r_total;
    logic [RangeW-1:0]        r_minor;
    logic [DimW-1:0]          r_dim;
    logic [DivDenW-1:0]       r_den;
    logic [StepW-1:0]         r_cnt;
    logic [DivQW-1:0]         r_major;

    logic [PosW-1:0]          r_pos_x, r_pos_y;
    logic [PosW-1:0]          r_inc_x, r_inc_y;
    logic [StepW-1:0]         r_steps;
    logic [3*ColorW-1:0]      r_line_color;
    logic                     r_active;

    t_status                  r_kind;
    logic [ProdW-1:0]         r_colp, r_rowp;
    logic [PixW-1:0]          r_col, r_row;
    logic [LinW-1:0]          r_lin;

    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [PixW-1:0]          r_out_x, r_out_y;
    logic [AddrW-1:0]         r_out_addr;
    logic [3*ColorW-1:0]      r_out_color;
    logic                     r_out_last;

    logic signed [CoordW-1:0] w_lx, w_ly, w_rx, w_ry, w_tx, w_ty, w_bx, w_by;
    logic signed [CoordW:0]   w_rng_x, w_rng_y;
    logic                     w_axis_y;
    logic signed [CoordW-1:0] w_sx, w_sy;
    logic [DimW-1:0]          w_dim_w, w_dim_h;
    logic [RangeW+DimW-1:0]   w_den_full;
    logic                     w_div_start;
    logic [DivNumW-1:0]       w_div_num;
    logic [DivDenW-1:0]       w_div_den;
    logic                     w_div_done;
    logic [DivQW-1:0]         w_quo;
    logic [PosW-1:0]          w_inc_major, w_inc_minor;
    logic                     w_can_step;
    logic                     w_neg, w_over;
    logic [PixW+1:0]          w_col_raw, w_row_raw;
    logic [FullW-1:0]         w_addr_full;

    assign w_dim_w = dim_of(r_frame_w);
    assign w_dim_h = dim_of(r_frame_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= DimW'(640);
            r_frame_h <= DimW'(480);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_frame_w <= i_cfg_data;
                CFG_HEIGHT: r_frame_h <= i_cfg_data;
                default:    r_frame_w <= r_frame_w;
            endcase
        end
    end

    always_comb begin
        w_lx = i_first_x;
        w_ly = i_first_y;
        w_rx = i_second_x;
        w_ry = i_second_y;
        w_tx = i_first_x;
        w_ty = i_first_y;
        w_bx = i_second_x;
        w_by = i_second_y;
        w_lx = r_x1; w_ly = r_y1; w_rx = r_x2; w_ry = r_y2;
        w_tx = r_x1; w_ty = r_y1; w_bx = r_x2; w_by = r_y2;
        if (r_x2 < r_x1) begin
            w_lx = r_x2; w_ly = r_y2; w_rx = r_x1; w_ry = r_y1;
        end
        if (r_y2 > r_y1) begin
            w_tx = r_x2; w_ty = r_y2; w_bx = r_x1; w_by = r_y1;
        end
    end

    assign w_rng_x  = {w_rx[CoordW-1], w_rx} - {w_lx[CoordW-1], w_lx};
    assign w_rng_y  = {w_ty[CoordW-1], w_ty} - {w_by[CoordW-1], w_by};
    assign w_axis_y = w_rng_y[RangeW-1:0] > w_rng_x[RangeW-1:0];
    assign w_sx     = w_axis_y ? w_bx : w_lx;
    assign w_sy     = w_axis_y ? w_by : w_ly;

    assign w_den_full = r_total * r_dim;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_x1       <= i_first_x;
            r_y1       <= i_first_y;
            r_x2       <= i_second_x;
            r_y2       <= i_second_y;
            r_color_in <= {i_red_in, i_green_in, i_blue_in};
        end
        if (i_cmd.prep) begin
            r_axis_y <= w_axis_y;
            r_total  <= w_axis_y ? w_rng_y[RangeW-1:0] : w_rng_x[RangeW-1:0];
            r_minor  <= w_axis_y ? w_rng_x[RangeW-1:0] : w_rng_y[RangeW-1:0];
            r_neg    <= w_axis_y ? (w_bx > w_tx) : (w_ly > w_ry);
            r_dim    <= w_axis_y ? w_dim_h : w_dim_w;
        end
        if (i_cmd.mul) begin
            r_den <= w_den_full[DivDenW-1:0];
            if (|w_den_full[RangeW+DimW-1:StepW+16]) begin
                r_cnt <= STEP_MAX;
            end else begin
                r_cnt <= w_den_full[StepW+15:16];
            end
        end
        if (i_cmd.take_major) begin
            r_major <= w_quo;
        end
    end

    always_comb begin
        w_div_start = i_cmd.start_major || i_cmd.start_minor;
        if (i_cmd.start_minor) begin
            w_div_num = {1'b0, r_minor, {FracW{1'b0}}} + DivNumW'(r_den >> 1);
            w_div_den = r_den;
        end else begin
            w_div_num = (DivNumW'(1) << FracW) + DivNumW'(r_dim >> 1);
            w_div_den = DivDenW'(r_dim);
        end
    end

    dda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_inc_major = PosW'(r_major);
    assign w_inc_minor = r_neg ? (PosW'(0) - PosW'(w_quo)) : PosW'(w_quo);
    assign w_can_step  = r_active && (r_steps != '0);
    assign w_neg       = r_pos_x[PosW-1] || r_pos_y[PosW-1];
    assign w_over      = (|r_pos_x[PosW-2:FracW+1])
                      || (r_pos_x[FracW] && (|r_pos_x[FracW-1:0]))
                      || (|r_pos_y[PosW-2:FracW+1])
                      || (r_pos_y[FracW] && (|r_pos_y[FracW-1:0]));
    assign w_col_raw   = r_colp[ProdW-1:FracW];
    assign w_row_raw   = r_rowp[ProdW-1:FracW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_steps  <= '0;
        end else begin
            if (i_cmd.zero_line) begin
                r_steps  <= '0;
                r_active <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_steps  <= r_cnt;
                r_active <= r_cnt != '0;
            end
            if (i_cmd.step_add) begin
                if (w_can_step) begin
                    r_steps <= r_steps - StepW'(1);
                    if (r_steps == StepW'(1)) begin
                        r_active <= 1'b0;
                    end
                end else begin
                    r_active <= 1'b0;
                end
            end
            if (i_cmd.step_pix && (r_kind == STS_PIXEL) && !w_neg && w_over) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_pos_x      <= {{(PosW-CoordW-16){w_sx[CoordW-1]}}, w_sx, 16'b0};
            r_pos_y      <= {{(PosW-CoordW-16){w_sy[CoordW-1]}}, w_sy, 16'b0};
            r_line_color <= r_color_in;
        end
        if (i_cmd.zero_line) begin
            r_inc_x <= '0;
            r_inc_y <= '0;
        end
        if (i_cmd.commit) begin
            r_inc_x <= r_axis_y ? w_inc_minor : w_inc_major;
            r_inc_y <= r_axis_y ? w_inc_major : w_inc_minor;
        end
        if (i_cmd.step_add) begin
            if (w_can_step) begin
                r_pos_x <= r_pos_x + r_inc_x;
                r_pos_y <= r_pos_y + r_inc_y;
                r_kind  <= STS_PIXEL;
            end else begin
                r_kind  <= STS_DONE;
            end
        end
        if (i_cmd.step_pix) begin
            r_colp <= r_pos_x[FracW:0] * w_dim_w;
            r_rowp <= r_pos_y[FracW:0] * w_dim_h;
            if (r_kind == STS_PIXEL) begin
                if (w_neg) begin
                    r_kind <= STS_SKIP;
                end else if (w_over) begin
                    r_kind <= STS_DONE;
                end
            end
        end
        if (i_cmd.step_clamp) begin
            r_col <= (w_col_raw >= (PixW+2)'(w_dim_w)) ? PixW'(w_dim_w - DimW'(1))
                                                      : w_col_raw[PixW-1:0];
            r_row <= (w_row_raw >= (PixW+2)'(w_dim_h)) ? PixW'(w_dim_h - DimW'(1))
                                                      : w_row_raw[PixW-1:0];
        end
        if (i_cmd.step_lin) begin
            r_lin <= (LinW'(r_row) * LinW'(w_dim_w)) + LinW'(r_col);
        end
    end

    assign w_addr_full = FullW'(r_lin) * FullW'(BYTES_PER_PIXEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_kind;
            r_out_last   <= !r_active;
            if (r_kind == STS_PIXEL) begin
                r_out_x     <= r_col;
                r_out_y     <= r_row;
                r_out_addr  <= w_addr_full[AddrW-1:0];
                r_out_color <= r_line_color;
            end else begin
                r_out_x     <= '0;
                r_out_y     <= '0;
                r_out_addr  <= '0;
                r_out_color <= '0;
            end
        end
    end

    assign o_sts.total_zero = r_total == '0;
    assign o_sts.div_done   = w_div_done;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_byte_address = r_out_addr;
    assign o_red_out      = r_out_color[3*ColorW-1:2*ColorW];
    assign o_green_out    = r_out_color[2*ColorW-1:ColorW];
    assign o_blue_out     = r_out_color[ColorW-1:0];
    assign o_last_pixel   = r_out_last;

    a_active_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_steps != '0))
        else $error("line active with no steps left");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != STS_PIXEL)) |->
        (r_out_x == '0 && r_out_y == '0 && r_out_addr == '0 && r_out_color == '0))
        else $error("skip or finished word carries pixel data");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STS_DONE)) |-> r_out_last)
        else $error("finished word without last_pixel");

endmodule

@@ src/dda_ctrl.sv @@
module dda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    output logic          o_in_stall,
    output dda_pkg::t_cmd o_cmd,
    input  dda_pkg::t_sts i_sts
);
    import dda_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_PREP  = 10'b00_0000_0010,
        S_MUL   = 10'b00_0000_0100,
        S_WMJ   = 10'b00_0000_1000,
        S_WMN   = 10'b00_0001_0000,
        S_ADD   = 10'b00_0010_0000,
        S_PIX   = 10'b00_0100_0000,
        S_CLMP  = 10'b00_1000_0000,
        S_LIN   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.cap = 1'b1;
                    n_state   = i_req_type ? S_ADD : S_PREP;
                end
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                if (i_sts.total_zero) begin
                    w_cmd.zero_line = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    w_cmd.start_major = 1'b1;
                    n_state           = S_WMJ;
                end
            end
            S_WMJ: begin
                if (i_sts.div_done) begin
                    w_cmd.take_major  = 1'b1;
                    w_cmd.start_minor = 1'b1;
                    n_state           = S_WMN;
                end
            end
            S_WMN: begin
                if (i_sts.div_done) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ADD: begin
                w_cmd.step_add = 1'b1;
                n_state        = S_PIX;
            end
            S_PIX: begin
                w_cmd.step_pix = 1'b1;
                n_state        = S_CLMP;
            end
            S_CLMP: begin
                w_cmd.step_clamp = 1'b1;
                n_state          = S_LIN;
            end
            S_LIN: begin
                w_cmd.step_lin = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;
    assign o_cmd      = w_cmd;

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_WMJ || r_state == S_WMN))
        else $error("divider finished outside a wait state");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.cap |=> (r_state == S_ADD || r_state == S_PREP))
        else $error("accepted word did not start work");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (r_state == S_OUT && i_sts.out_free))
        else $error("output register overwritten");

endmodule

@@ src/dda_line_rasterizer.sv @@
// DDA line rasterizer, normalized Q2.16 endpoints to frame pixels.
// Input channel (i_in_valid / o_in_stall): a load word (i_req_type 0) sets up a
// line from two endpoints and a color and gives no result; a step word
// (i_req_type 1) advances one step and gives exactly one result word.
// Output channel (o_out_valid / i_out_stall): status, pixel column and row,
// byte address, color and last_pixel.
// Config port (i_cfg_we, i_cfg_index, i_cfg_data): 0 frame width, 1 frame height;
// write only while no word is in flight.
// Step word: the add, pixel, clamp and linear states run, then the output state
// loads the result once the output register is free; the controller is idle
// again as the result enters it and takes no new word before then. The address
// multiply is the last of four per-step stages. Load word: two passes of the
// shared radix-2 divider, 33 quotient bits each (major then minor increment);
// none when both endpoints span no range on the major axis.
// Reset: no line active, frame 640 x 480, output empty.
// Output stall: the result word holds; the next step's result waits in the
// controller until the output register frees, while a load word still runs.
module dda_line_rasterizer #(
    parameter int BYTES_PER_PIXEL = 4,
    parameter int MAX_DIM         = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic signed [dda_pkg::CoordW-1:0] i_first_x,
    input  logic signed [dda_pkg::CoordW-1:0] i_first_y,
    input  logic signed [dda_pkg::CoordW-1:0] i_second_x,
    input  logic signed [dda_pkg::CoordW-1:0] i_second_y,
    input  logic [dda_pkg::ColorW-1:0]        i_red_in,
    input  logic [dda_pkg::ColorW-1:0]        i_green_in,
    input  logic [dda_pkg::ColorW-1:0]        i_blue_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [dda_pkg::PixW-1:0]          o_pixel_x,
    output logic [dda_pkg::PixW-1:0]          o_pixel_y,
    output logic [dda_pkg::AddrW-1:0]         o_byte_address,
    output logic [dda_pkg::ColorW-1:0]        o_red_out,
    output logic [dda_pkg::ColorW-1:0]        o_green_out,
    output logic [dda_pkg::ColorW-1:0]        o_blue_out,
    output logic                              o_last_pixel,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [dda_pkg::DimW-1:0]          i_cfg_data
);
    import dda_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    dda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    dda_dp #(
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
        .MAX_DIM         (MAX_DIM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_byte_address (o_byte_address),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_last_pixel   (o_last_pixel)
    );

endmodule

@@ test/tb_dda_line_rasterizer.sv @@
module tb_dda_line_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int        BPP        = 4;
    localparam int        FRAME_MAX  = 4096;
    localparam int        SETTLE     = 100;
    localparam int        PHASE_HALF = 40;
    localparam logic      REQ_LOAD   = 1'b0;
    localparam logic      REQ_STEP   = 1'b1;
    localparam logic      CFG_WIDTH  = 1'b0;
    localparam logic      CFG_HEIGHT = 1'b1;
    localparam longint    ONE_Q32    = 64'sd4294967296;

    typedef struct packed {
        logic              kind;
        logic [CoordW-1:0] ax;
        logic [CoordW-1:0] ay;
        logic [CoordW-1:0] bx;
        logic [CoordW-1:0] by;
        logic [ColorW-1:0] red;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] blue;
    } t_line_req;

    typedef struct packed {
        t_status           status;
        logic [PixW-1:0]   pixel_x;
        logic [PixW-1:0]   pixel_y;
        logic [AddrW-1:0]  byte_address;
        logic [ColorW-1:0] red;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] blue;
        logic              last;
    } t_pixel_word;

    class line_scoreboard;
        logic [DimW-1:0]  width_reg;
        logic [DimW-1:0]  height_reg;
        logic [PosW-1:0]  pos_x;
        logic [PosW-1:0]  pos_y;
        logic [PosW-1:0]  inc_x;
        logic [PosW-1:0]  inc_y;
        logic [StepW-1:0] steps_left;
        logic [23:0]      color;
        logic             active;
        t_pixel_word      pending[$];
        int               errors;

        function new();
            errors     = 0;
            width_reg  = 640;
            height_reg = 480;
            pos_x      = '0;
            pos_y      = '0;
            inc_x      = '0;
            inc_y      = '0;
            steps_left = '0;
            color      = '0;
            active     = 1'b0;
        endfunction

        function void set_frame(logic idx, logic [DimW-1:0] value);
            if (idx == CFG_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function longint unsigned frame_dim(logic [DimW-1:0] r);
            if (r == 0) return 1;
            if (r > FRAME_MAX) return FRAME_MAX;
            return r;
        endfunction

        function void load_line(t_line_req w);
            longint x1, y1, x2, y2, lx, ly, rx, ry, tx, ty, bx, by;
            longint rng_x, rng_y, total, minor, sx, sy, minc;
            longint unsigned dim, major, den, cnt;
            logic y_major;
            x1 = longint'($signed(w.ax));
            y1 = longint'($signed(w.ay));
            x2 = longint'($signed(w.bx));
            y2 = longint'($signed(w.by));
            lx = x1; ly = y1; rx = x2; ry = y2;
            tx = x1; ty = y1; bx = x2; by = y2;
            if (x2 < x1) begin
                lx = x2; ly = y2; rx = x1; ry = y1;
            end
            if (y2 > y1) begin
                tx = x2; ty = y2; bx = x1; by = y1;
            end
            rng_x   = rx - lx;
            rng_y   = ty - by;
            y_major = rng_y > rng_x;
            dim     = y_major ? frame_dim(height_reg) : frame_dim(width_reg);
            total   = y_major ? rng_y : rng_x;
            minor   = y_major ? rng_x : rng_y;
            sx      = y_major ? bx : lx;
            sy      = y_major ? by : ly;
            color   = {w.red, w.green, w.blue};
            pos_x   = PosW'(sx * 65536);
            pos_y   = PosW'(sy * 65536);
            if (total <= 0) begin
                inc_x      = '0;
                inc_y      = '0;
                steps_left = '0;
                active     = 1'b0;
                return;
            end
            major = ((64'd1 << FracW) + dim / 2) / dim;
            den   = unsigned'(total) * dim;
            minc  = longint'(((unsigned'(minor) << FracW) + den / 2) / den);
            if (y_major) begin
                if (bx > tx) minc = -minc;
                inc_y = PosW'(major);
                inc_x = PosW'(minc);
            end else begin
                if (ly > ry) minc = -minc;
                inc_x = PosW'(major);
                inc_y = PosW'(minc);
            end
            cnt = (unsigned'(total) * dim) >> 16;
            if (cnt > STEP_MAX) cnt = STEP_MAX;
            steps_left = StepW'(cnt);
            active     = cnt != 0;
        endfunction

        function t_pixel_word advance();
            t_pixel_word r;
            longint px, py;
            longint unsigned w, h, col, row;
            r = '0;
            if (!active || steps_left == 0) begin
                active   = 1'b0;
                r.status = STS_DONE;
                r.last   = 1'b1;
                return r;
            end
            steps_left = steps_left - 1'b1;
            pos_x      = pos_x + inc_x;
            pos_y      = pos_y + inc_y;
            if (steps_left == 0) active = 1'b0;
            px = longint'($signed(pos_x));
            py = longint'($signed(pos_y));
            if (px < 0 || py < 0) begin
                r.status = STS_SKIP;
                r.last   = !active;
                return r;
            end
            if (px > ONE_Q32 || py > ONE_Q32) begin
                active   = 1'b0;
                r.status = STS_DONE;
                r.last   = 1'b1;
                return r;
            end
            w   = frame_dim(width_reg);
            h   = frame_dim(height_reg);
            col = (unsigned'(px) * w) >> FracW;
            row = (unsigned'(py) * h) >> FracW;
            if (col >= w) col = w - 1;
            if (row >= h) row = h - 1;
            r.status       = STS_PIXEL;
            r.pixel_x      = PixW'(col);
            r.pixel_y      = PixW'(row);
            r.byte_address = AddrW'((row * w + col) * BPP);
            r.red          = color[23:16];
            r.green        = color[15:8];
            r.blue         = color[7:0];
            r.last         = !active;
            return r;
        endfunction

        function void note_word(t_line_req w);
            if (w.kind == REQ_LOAD) begin
                load_line(w);
            end else begin
                pending.push_back(advance());
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
        endfunction

        function void check(t_pixel_word got);
            t_pixel_word want;
            if (pending.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.pixel_x !== want.pixel_x)
                report($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
            if (got.byte_address !== want.byte_address)
                report($sformatf("byte_address got %0d want %0d",
                                 got.byte_address, want.byte_address));
            if (got.red !== want.red)
                report($sformatf("red got %0d want %0d", got.red, want.red));
            if (got.green !== want.green)
                report($sformatf("green got %0d want %0d", got.green, want.green));
            if (got.blue !== want.blue)
                report($sformatf("blue got %0d want %0d", got.blue, want.blue));
            if (got.last !== want.last)
                report($sformatf("last_pixel got %0d want %0d", got.last, want.last));
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_req_type;
    logic [CoordW-1:0] i_first_x;
    logic [CoordW-1:0] i_first_y;
    logic [CoordW-1:0] i_second_x;
    logic [CoordW-1:0] i_second_y;
    logic [ColorW-1:0] i_red_in;
    logic [ColorW-1:0] i_green_in;
    logic [ColorW-1:0] i_blue_in;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_status;
    logic [PixW-1:0]   o_pixel_x;
    logic [PixW-1:0]   o_pixel_y;
    logic [AddrW-1:0]  o_byte_address;
    logic [ColorW-1:0] o_red_out;
    logic [ColorW-1:0] o_green_out;
    logic [ColorW-1:0] o_blue_out;
    logic              o_last_pixel;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [DimW-1:0]   i_cfg_data;

    logic              calm = 1'b0;
    int                stall_run = 0;
    int                free_run = 0;
    line_scoreboard    sb = new();

    dda_line_rasterizer #(
        .BYTES_PER_PIXEL(BPP),
        .MAX_DIM        (FRAME_MAX)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_byte_address(o_byte_address),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_last_pixel  (o_last_pixel),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run   <= stall_run - 1;
            i_out_stall <= 1'b1;
        end else if (free_run > 0) begin
            free_run    <= free_run - 1;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_run   <= $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            free_run    <= $urandom_range(1, 30);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_pixel_word got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status       = t_status'(o_status);
            got.pixel_x      = o_pixel_x;
            got.pixel_y      = o_pixel_y;
            got.byte_address = o_byte_address;
            got.red          = o_red_out;
            got.green        = o_green_out;
            got.blue         = o_blue_out;
            got.last         = o_last_pixel;
            sb.check(got);
        end
    end

    function automatic t_line_req line_word(int ax, int ay, int bx, int by,
                                            int red, int green, int blue);
        t_line_req w;
        w.kind  = REQ_LOAD;
        w.ax    = CoordW'(ax);
        w.ay    = CoordW'(ay);
        w.bx    = CoordW'(bx);
        w.by    = CoordW'(by);
        w.red   = ColorW'(red);
        w.green = ColorW'(green);
        w.blue  = ColorW'(blue);
        return w;
    endfunction

    function automatic t_line_req step_word();
        t_line_req w;
        w      = t_line_req'({$urandom(), $urandom(), $urandom(), $urandom()});
        w.kind = REQ_STEP;
        return w;
    endfunction

    function automatic logic [CoordW-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return CoordW'($urandom());
            1:       return '0;
            2:       return CoordW'(65536);
            3:       return CoordW'(65535);
            4:       return CoordW'(int'($urandom_range(60000, 70000)));
            default: return CoordW'(int'($urandom_range(0, 81920)) - 8192);
        endcase
    endfunction

    function automatic t_line_req random_line();
        t_line_req w;
        w       = step_word();
        w.kind  = REQ_LOAD;
        w.ax    = pick_coord();
        w.ay    = pick_coord();
        w.bx    = pick_coord();
        w.by    = pick_coord();
        if ($urandom_range(0, 15) == 0) begin
            w.bx = w.ax;
            w.by = w.ay;
        end
        return w;
    endfunction

    // caller sits just after a falling edge; returns just after one
    task automatic send_word(input t_line_req w);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
        repeat (gap) @(negedge i_clk);
        i_req_type = w.kind;
        i_first_x  = w.ax;
        i_first_y  = w.ay;
        i_second_x = w.bx;
        i_second_y = w.by;
        i_red_in   = w.red;
        i_green_in = w.green;
        i_blue_in  = w.blue;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(w);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_idle(input int settle);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_frame(input logic idx, input int value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = DimW'(value);
        @(posedge i_clk);
        sb.set_frame(idx, DimW'(value));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_lines(input int count);
        int sent;
        int run;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_word(step_word());
                end else begin
                    send_word(t_line_req'({REQ_LOAD, CoordW'($urandom()), CoordW'($urandom()),
                                           CoordW'($urandom()), CoordW'($urandom()),
                                           24'($urandom())}));
                end
                sent++;
            end else begin
                send_word(random_line());
                run = $urandom_range(0, 20);
                repeat (run) send_word(step_word());
                sent += run + 1;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_LOAD;
        i_first_x   = '0;
        i_first_y   = '0;
        i_second_x  = '0;
        i_second_y  = '0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(step_word());
        send_word(line_word(32768, 32768, 32768, 32768, 0, 0, 0));
        send_word(step_word());
        send_word(line_word(-131072, -131072, 131071, 131071, 255, 255, 255));
        repeat (2) send_word(step_word());

        wait_idle(SETTLE);
        set_frame(CFG_WIDTH, 4);
        set_frame(CFG_HEIGHT, 4);
        send_word(line_word(0, 0, 65536, 65536, 255, 0, 128));
        repeat (5) send_word(step_word());
        send_word(line_word(65536, 0, 0, 131071, 18, 52, 86));
        repeat (2) send_word(step_word());
        send_word(line_word(0, -65536, 131071, -32768, 1, 2, 3));
        repeat (5) send_word(step_word());

        wait_idle(SETTLE);
        set_frame(CFG_WIDTH, 8191);
        set_frame(CFG_HEIGHT, 0);
        send_word(line_word(-131072, 0, 131071, 65535, 170, 85, 0));
        send_word(step_word());

        wait_idle(SETTLE);
        set_frame(CFG_WIDTH, FRAME_MAX);
        set_frame(CFG_HEIGHT, FRAME_MAX);
        send_word(line_word(65535, 65535, 65536, 65536, 9, 9, 9));
        send_word(step_word());

        for (int p = 0; p < 6; p++) begin
            wait_idle(SETTLE);
            case (p)
                0: begin
                    set_frame(CFG_WIDTH, $urandom_range(1, 16));
                    set_frame(CFG_HEIGHT, $urandom_range(1, 16));
                end
                1: begin
                    set_frame(CFG_WIDTH, 1);
                    set_frame(CFG_HEIGHT, 1);
                end
                2: begin
                    set_frame(CFG_WIDTH, FRAME_MAX);
                    set_frame(CFG_HEIGHT, FRAME_MAX);
                end
                3: begin
                    set_frame(CFG_WIDTH, 0);
                    set_frame(CFG_HEIGHT, 8191);
                end
                4: begin
                    set_frame(CFG_WIDTH, $urandom_range(0, 8191));
                    set_frame(CFG_HEIGHT, $urandom_range(0, 8191));
                end
                default: begin
                    calm = 1'b1;
                    set_frame(CFG_WIDTH, $urandom_range(1, 64));
                    set_frame(CFG_HEIGHT, $urandom_range(1, 64));
                end
            endcase
            run_lines(PHASE_HALF);
            // hold off until the output side has caught up
            wait_idle(0);
            run_lines(PHASE_HALF);
        end

        wait_idle(SETTLE);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
